@@ rtl/core/csie_pkg.sv @@
// Shared types and encodings for the CPU instruction subset execute block.
package csie_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_RETIRE  = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    // Outstanding read codes.
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_LOADA = 2'd1;
    localparam logic [1:0] PEND_RETLO = 2'd2;
    localparam logic [1:0] PEND_RETHI = 2'd3;

    // Flag bit positions.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Opcodes of the supported subset.
    localparam logic [7:0] OP_JP      = 8'hC3;
    localparam logic [7:0] OP_JP_NZ   = 8'hC2;
    localparam logic [7:0] OP_JP_Z    = 8'hCA;
    localparam logic [7:0] OP_JP_C    = 8'hDA;
    localparam logic [7:0] OP_JR      = 8'h18;
    localparam logic [7:0] OP_CALL    = 8'hCD;
    localparam logic [7:0] OP_RET     = 8'hC9;
    localparam logic [7:0] OP_LD_A_D8 = 8'h3E;
    localparam logic [7:0] OP_LD_B_D8 = 8'h06;
    localparam logic [7:0] OP_LD_C_D8 = 8'h0E;
    localparam logic [7:0] OP_LD_BC   = 8'h01;
    localparam logic [7:0] OP_LD_DE   = 8'h11;
    localparam logic [7:0] OP_LD_HL   = 8'h21;
    localparam logic [7:0] OP_ST_A16  = 8'hEA;
    localparam logic [7:0] OP_LD_A16  = 8'hFA;
    localparam logic [7:0] OP_LD_A_DE = 8'h1A;
    localparam logic [7:0] OP_ST_HLI  = 8'h22;
    localparam logic [7:0] OP_INC_DE  = 8'h13;
    localparam logic [7:0] OP_DEC_BC  = 8'h0B;
    localparam logic [7:0] OP_LD_A_B  = 8'h78;
    localparam logic [7:0] OP_OR_C    = 8'hB1;
    localparam logic [7:0] OP_CP_D8   = 8'hFE;
    localparam logic [7:0] OP_PUSH_BC = 8'hC5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } result_t;

    // Everything one instruction produces: up to three results plus the
    // architectural state that every one of them reports.
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
        logic [15:0]       pc_value;
        logic [7:0]        acc_value;
        logic [3:0]        flag_value;
    } pack_t;

endpackage

@@ rtl/core/csie_exec.sv @@
// Register file, program counter and single-pass instruction execute logic.
module csie_exec
    import csie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        action,
    input  logic [7:0]  opcode,
    input  logic [7:0]  operand_low,
    input  logic [7:0]  operand_high,
    input  logic [7:0]  read_data,
    output pack_t       pack
);

    logic [7:0]  acc_reg, acc_next;
    logic [3:0]  flag_reg, flag_next;
    logic [7:0]  b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [7:0]  e_reg, e_next, h_reg, h_next, l_reg, l_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] pc_reg, pc_next;
    logic [1:0]  pend_reg, pend_next;
    logic [7:0]  hold_reg, hold_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 8'h00;
            flag_reg <= 4'h0;
            b_reg    <= 8'h00;
            c_reg    <= 8'h00;
            d_reg    <= 8'h00;
            e_reg    <= 8'h00;
            h_reg    <= 8'h00;
            l_reg    <= 8'h00;
            sp_reg   <= 16'hFFFE;
            pc_reg   <= 16'h0100;
            pend_reg <= PEND_NONE;
            hold_reg <= 8'h00;
        end
        else if (fire)
        begin
            acc_reg  <= acc_next;
            flag_reg <= flag_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
            e_reg    <= e_next;
            h_reg    <= h_next;
            l_reg    <= l_next;
            sp_reg   <= sp_next;
            pc_reg   <= pc_next;
            pend_reg <= pend_next;
            hold_reg <= hold_next;
        end
    end

    always_comb
    begin
        logic [15:0] a16;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] ret_addr;
        logic [7:0]  or_val;

        a16      = {operand_high, operand_low};
        bc       = {b_reg, c_reg};
        de       = {d_reg, e_reg};
        hl       = {h_reg, l_reg};
        ret_addr = pc_reg + 16'd3;
        or_val   = acc_reg | c_reg;

        acc_next  = acc_reg;
        flag_next = flag_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        h_next    = h_reg;
        l_next    = l_reg;
        sp_next   = sp_reg;
        pc_next   = pc_reg;
        pend_next = pend_reg;
        hold_next = hold_reg;

        pack.count = 2'd0;
        pack.res   = '0;
        pack.res[0].kind = KIND_RETIRE;

        if (action)
        begin
            unique case (pend_reg)
                PEND_LOADA:
                begin
                    acc_next   = read_data;
                    pend_next  = PEND_NONE;
                    pack.count = 2'd1;
                end
                PEND_RETLO:
                begin
                    hold_next  = read_data;
                    pend_next  = PEND_RETHI;
                    pack.count = 2'd1;
                    pack.res[0].kind    = KIND_READ;
                    pack.res[0].address = sp_reg + 16'd1;
                end
                PEND_RETHI:
                begin
                    pc_next    = {read_data, hold_reg};
                    sp_next    = sp_reg + 16'd2;
                    pend_next  = PEND_NONE;
                    pack.count = 2'd1;
                end
                default:
                begin
                    // A returned byte with no read outstanding is dropped.
                    pack.count = 2'd0;
                end
            endcase
        end
        else
        begin
            pend_next  = PEND_NONE;
            pack.count = 2'd1;
            unique case (opcode)
                OP_JP:    pc_next = a16;
                OP_JP_NZ: pc_next = flag_reg[FLAG_Z] ? ret_addr : a16;
                OP_JP_Z:  pc_next = flag_reg[FLAG_Z] ? a16 : ret_addr;
                OP_JP_C:  pc_next = flag_reg[FLAG_C] ? a16 : ret_addr;
                OP_JR:    pc_next = pc_reg + 16'd2 + {{8{operand_low[7]}}, operand_low};
                OP_CALL:
                begin
                    sp_next    = sp_reg - 16'd2;
                    pc_next    = a16;
                    pack.count = 2'd3;
                    pack.res[0].kind    = KIND_WRITE;
                    pack.res[0].address = sp_reg - 16'd1;
                    pack.res[0].data    = ret_addr[15:8];
                    pack.res[1].kind    = KIND_WRITE;
                    pack.res[1].address = sp_reg - 16'd2;
                    pack.res[1].data    = ret_addr[7:0];
                    pack.res[2].kind    = KIND_RETIRE;
                end
                OP_RET:
                begin
                    pend_next = PEND_RETLO;
                    pack.res[0].kind    = KIND_READ;
                    pack.res[0].address = sp_reg;
                end
                OP_LD_A_D8:
                begin
                    acc_next = operand_low;
                    pc_next  = pc_reg + 16'd2;
                end
                OP_LD_B_D8:
                begin
                    b_next  = operand_low;
                    pc_next = pc_reg + 16'd2;
                end
                OP_LD_C_D8:
                begin
                    c_next  = operand_low;
                    pc_next = pc_reg + 16'd2;
                end
                OP_LD_BC:
                begin
                    b_next  = operand_high;
                    c_next  = operand_low;
                    pc_next = ret_addr;
                end
                OP_LD_DE:
                begin
                    d_next  = operand_high;
                    e_next  = operand_low;
                    pc_next = ret_addr;
                end
                OP_LD_HL:
                begin
                    h_next  = operand_high;
                    l_next  = operand_low;
                    pc_next = ret_addr;
                end
                OP_ST_A16:
                begin
                    pc_next    = ret_addr;
                    pack.count = 2'd2;
                    pack.res[0].kind    = KIND_WRITE;
                    pack.res[0].address = a16;
                    pack.res[0].data    = acc_reg;
                    pack.res[1].kind    = KIND_RETIRE;
                end
                OP_LD_A16:
                begin
                    pc_next   = ret_addr;
                    pend_next = PEND_LOADA;
                    pack.res[0].kind    = KIND_READ;
                    pack.res[0].address = a16;
                end
                OP_LD_A_DE:
                begin
                    pc_next   = pc_reg + 16'd1;
                    pend_next = PEND_LOADA;
                    pack.res[0].kind    = KIND_READ;
                    pack.res[0].address = de;
                end
                OP_ST_HLI:
                begin
                    {h_next, l_next} = hl + 16'd1;
                    pc_next    = pc_reg + 16'd1;
                    pack.count = 2'd2;
                    pack.res[0].kind    = KIND_WRITE;
                    pack.res[0].address = hl;
                    pack.res[0].data    = acc_reg;
                    pack.res[1].kind    = KIND_RETIRE;
                end
                OP_INC_DE:
                begin
                    {d_next, e_next} = de + 16'd1;
                    pc_next = pc_reg + 16'd1;
                end
                OP_DEC_BC:
                begin
                    {b_next, c_next} = bc - 16'd1;
                    pc_next = pc_reg + 16'd1;
                end
                OP_LD_A_B:
                begin
                    acc_next = b_reg;
                    pc_next  = pc_reg + 16'd1;
                end
                OP_OR_C:
                begin
                    acc_next  = or_val;
                    flag_next = {(or_val == 8'h00), 3'b000};
                    pc_next   = pc_reg + 16'd1;
                end
                OP_CP_D8:
                begin
                    flag_next[FLAG_Z] = (acc_reg == operand_low);
                    flag_next[FLAG_N] = 1'b1;
                    flag_next[FLAG_H] = (acc_reg[3:0] < operand_low[3:0]);
                    flag_next[FLAG_C] = (acc_reg < operand_low);
                    pc_next = pc_reg + 16'd2;
                end
                OP_PUSH_BC:
                begin
                    sp_next    = sp_reg - 16'd2;
                    pc_next    = pc_reg + 16'd1;
                    pack.count = 2'd3;
                    pack.res[0].kind    = KIND_WRITE;
                    pack.res[0].address = sp_reg - 16'd1;
                    pack.res[0].data    = b_reg;
                    pack.res[1].kind    = KIND_WRITE;
                    pack.res[1].address = sp_reg - 16'd2;
                    pack.res[1].data    = c_reg;
                    pack.res[2].kind    = KIND_RETIRE;
                end
                default:
                begin
                    pc_next = pc_reg + 16'd1;
                    pack.res[0].kind = KIND_INVALID;
                end
            endcase
        end

        // Every result reports the state as it stands after the instruction.
        pack.pc_value   = pc_next;
        pack.acc_value  = acc_next;
        pack.flag_value = flag_next;
    end

endmodule

@@ rtl/core/csie_out_buf.sv @@
// Result register that holds one instruction's results and sends one per cycle unless stalled.
module csie_out_buf
    import csie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  pack_t       pack,
    output logic        ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // address[15:0], data, pc_value, acc_value, flag_value, pad
    output logic [1:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast
);

    result_t [2:0] res_reg;
    logic [1:0]    cnt_reg;
    logic [1:0]    idx_reg;
    logic [15:0]   pc_reg;
    logic [7:0]    acc_reg;
    logic [3:0]    flag_reg;
    logic          final_one;
    logic          xfer;
    result_t       cur;

    assign final_one     = (idx_reg == (cnt_reg - 2'd1));
    assign xfer          = m_axis_tvalid && m_axis_tready;
    assign ready         = (cnt_reg == 2'd0) || (xfer && final_one);
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign cur           = res_reg[idx_reg];
    assign m_axis_tuser  = cur.kind;
    assign m_axis_tlast  = final_one;
    assign m_axis_tdata  = {4'h0, flag_reg, acc_reg, pc_reg, cur.data, cur.address};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load && ready)
        begin
            cnt_reg <= pack.count;
            idx_reg <= 2'd0;
        end
        else if (xfer)
        begin
            if (final_one)
            begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            res_reg  <= pack.res;
            pc_reg   <= pack.pc_value;
            acc_reg  <= pack.acc_value;
            flag_reg <= pack.flag_value;
        end
    end

endmodule

@@ rtl/core/cpu_instruction_subset_execute_top.sv @@
// Top level of the CPU instruction subset execute block.
//
//  Channel  | Dir | tdata (low bit up)                                   | tuser  | tlast
//  s_axis   | in  | opcode, operand_low, operand_high, read_data (32 b)  | action | -
//  m_axis   | out | address, data, pc_value, acc_value, flag_value (56 b)| kind   | last
//
// An accepted item is executed while it sits in the input register; its results enter the
// result register when that is ready and leave it one per cycle unless m_axis_tready stalls.
// An item with one result sustains one item per cycle when not stalled; CALL and PUSH give
// three results and stores two, which the one-result-per-cycle output register sends in turn.
// Reset puts A, flags and B..L at zero, SP at 0xFFFE and PC at 0x0100, no read outstanding.
// A stalled output holds the input register; one more item may wait there meanwhile.
module cpu_instruction_subset_execute_top
    import csie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // opcode, operand_low, operand_high, read_data
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // address, data, pc_value, acc_value, flag_value, pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    logic        in_valid_reg;
    logic        action_reg;
    logic [31:0] item_reg;
    logic        buf_ready;
    logic        exec_fire;
    pack_t       pack;

    assign exec_fire     = in_valid_reg && buf_ready;
    assign s_axis_tready = !in_valid_reg || exec_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            action_reg <= s_axis_tuser;
            item_reg   <= s_axis_tdata;
        end
    end

    csie_exec u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (exec_fire),
        .action       (action_reg),
        .opcode       (item_reg[7:0]),
        .operand_low  (item_reg[15:8]),
        .operand_high (item_reg[23:16]),
        .read_data    (item_reg[31:24]),
        .pack         (pack)
    );

    csie_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (exec_fire),
        .pack          (pack),
        .ready         (buf_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
